FILE: sv/gtg_pkg.sv
// Shared types and constants for the go-to-goal heading controller.
package gtg_pkg;

  // Datapath widths
  localparam int XY_W        = 20;  // CORDIC x/y, covers 17 bit deltas times the CORDIC gain
  localparam int Z_W         = 16;  // bearing accumulator, Q3.12
  localparam int HEADING_W   = 15;
  localparam int POS_W       = 16;
  localparam int TOL_W       = 15;
  localparam int SPEED_W     = 15;
  localparam int GAIN_W      = 8;
  localparam int RATE_W      = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int PROD_W      = Z_W + GAIN_W + 1;

  localparam int ATAN_ENTRIES = 21;
  localparam logic signed [Z_W-1:0] HALF_PI_Q12 = 16'sd6434;

  // atan(2^-i) in Q3.12, rounded
  localparam logic signed [Z_W-1:0] ATAN_Q12 [ATAN_ENTRIES] = '{
    16'sd3217, 16'sd1899, 16'sd1003, 16'sd509, 16'sd256, 16'sd128, 16'sd64,
    16'sd32, 16'sd16, 16'sd8, 16'sd4, 16'sd2, 16'sd1,
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
  };

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET_X  = 3'd0,
    REG_TARGET_Y  = 3'd1,
    REG_POS_TOL   = 3'd2,
    REG_ANGLE_TOL = 3'd3,
    REG_FWD_SPEED = 3'd4,
    REG_TURN_GAIN = 3'd5
  } cfg_reg_t;

  // Motion mode codes
  typedef enum logic [1:0] {
    MODE_TURN   = 2'd0,
    MODE_DRIVE  = 2'd1,
    MODE_ARRIVE = 2'd2
  } mode_t;

  // Payload carried between CORDIC stages
  typedef struct packed {
    logic signed [XY_W-1:0]      x;
    logic signed [XY_W-1:0]      y;
    logic signed [Z_W-1:0]       z;
    logic signed [HEADING_W-1:0] heading;
    logic                        arrived;
  } vec_t;

endpackage

FILE: sv/go_to_goal_heading_controller.sv
// Top level of the go-to-goal heading controller.
// Takes one pose item per cycle while in_tready is high and returns one command item
// per pose, in order. Stages: one for the target deltas and arrival check, one
// register stage per CORDIC iteration (capped at 21), one for the gain multiply and
// one for saturation and the output register. Every stage holds its item under
// backpressure and empty stages keep filling, so with out_tready high the sustained
// rate is one item per clock. Target and tolerance registers are set through the cfg
// port; the user must write them only while no item is in flight, unenforced here.
module go_to_goal_heading_controller
  import gtg_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 14
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Pose input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // pose_x[15:0], pose_y[31:16], pose_heading[46:32]
  // Command output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata   // linear_speed[14:0], angular_rate[30:15],
                                            // motion_mode[32:31]
);

  localparam int NUM_ITER = (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS
                                                               : ATAN_ENTRIES;

  // Configuration registers
  logic signed [POS_W-1:0] target_x_r;
  logic signed [POS_W-1:0] target_y_r;
  logic [TOL_W-1:0]        pos_tol_r;
  logic [TOL_W-1:0]        angle_tol_r;
  logic [SPEED_W-1:0]      fwd_speed_r;
  logic [GAIN_W-1:0]       turn_gain_r;

  logic                     stg_vld [NUM_ITER+1];
  logic                     stg_rdy [NUM_ITER+1];
  vec_t                     stg_dat [NUM_ITER+1];

  logic [SPEED_W-1:0]       linear_speed;
  logic signed [RATE_W-1:0] angular_rate;
  mode_t                    motion_mode;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r  <= 16'sd1280;
      target_y_r  <= 16'sd1280;
      pos_tol_r   <= 15'd128;
      angle_tol_r <= 15'd410;
      fwd_speed_r <= 15'd512;
      turn_gain_r <= 8'd32;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_TARGET_X:  target_x_r  <= cfg_wdata;
        REG_TARGET_Y:  target_y_r  <= cfg_wdata;
        REG_POS_TOL:   pos_tol_r   <= cfg_wdata[TOL_W-1:0];
        REG_ANGLE_TOL: angle_tol_r <= cfg_wdata[TOL_W-1:0];
        REG_FWD_SPEED: fwd_speed_r <= cfg_wdata[SPEED_W-1:0];
        REG_TURN_GAIN: turn_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  gtg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .vld_i        (in_tvalid),
    .rdy_o        (in_tready),
    .pose_x       (in_tdata[15:0]),
    .pose_y       (in_tdata[31:16]),
    .pose_heading (in_tdata[46:32]),
    .target_x     (target_x_r),
    .target_y     (target_y_r),
    .pos_tol      (pos_tol_r),
    .vld_o        (stg_vld[0]),
    .rdy_i        (stg_rdy[0]),
    .dat_o        (stg_dat[0])
  );

  // One register stage per CORDIC iteration
  for (genvar i = 0; i < NUM_ITER; i++) begin : g_cordic
    gtg_cordic_stage #(.SHIFT(i)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (stg_vld[i]),
      .rdy_o (stg_rdy[i]),
      .dat_i (stg_dat[i]),
      .vld_o (stg_vld[i+1]),
      .rdy_i (stg_rdy[i+1]),
      .dat_o (stg_dat[i+1])
    );
  end

  gtg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .vld_i        (stg_vld[NUM_ITER]),
    .rdy_o        (stg_rdy[NUM_ITER]),
    .dat_i        (stg_dat[NUM_ITER]),
    .angle_tol    (angle_tol_r),
    .fwd_speed    (fwd_speed_r),
    .turn_gain    (turn_gain_r),
    .vld_o        (out_tvalid),
    .rdy_i        (out_tready),
    .linear_speed (linear_speed),
    .angular_rate (angular_rate),
    .motion_mode  (motion_mode)
  );

  assign out_tdata = {7'b0, motion_mode, angular_rate, linear_speed};

  // Arrived items carry no motion command
  a_arrive_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && motion_mode == MODE_ARRIVE |-> linear_speed == '0 && angular_rate == '0)
    else $error("arrived item carries a motion command");

  // Driving items never turn, turning items never drive
  a_drive_no_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && motion_mode == MODE_DRIVE |-> angular_rate == '0)
    else $error("driving item has a turn rate");

  a_turn_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && motion_mode == MODE_TURN |-> linear_speed == '0)
    else $error("turning item has a forward speed");

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

FILE: sv/gtg_front.sv
// Front stage: target deltas, arrival check and quadrant pre-rotation.
module gtg_front
  import gtg_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  output logic                        rdy_o,
  input  logic signed [POS_W-1:0]     pose_x,
  input  logic signed [POS_W-1:0]     pose_y,
  input  logic signed [HEADING_W-1:0] pose_heading,
  input  logic signed [POS_W-1:0]     target_x,
  input  logic signed [POS_W-1:0]     target_y,
  input  logic [TOL_W-1:0]            pos_tol,
  output logic                        vld_o,
  input  logic                        rdy_i,
  output vec_t                        dat_o
);

  logic        vld_r;
  vec_t        dat_r;
  vec_t        dat_nxt;
  logic signed [POS_W:0] dx;
  logic signed [POS_W:0] dy;
  logic [POS_W:0]        adx;
  logic [POS_W:0]        ady;
  logic signed [XY_W-1:0] dx_e;
  logic signed [XY_W-1:0] dy_e;

  assign rdy_o = !vld_r || rdy_i;

  // Deltas to the target and the per-axis band check
  always_comb begin
    dx   = $signed({target_x[POS_W-1], target_x}) - $signed({pose_x[POS_W-1], pose_x});
    dy   = $signed({target_y[POS_W-1], target_y}) - $signed({pose_y[POS_W-1], pose_y});
    adx  = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
    ady  = dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
    dx_e = XY_W'(dx);
    dy_e = XY_W'(dy);
    dat_nxt.heading = pose_heading;
    dat_nxt.arrived = (adx <= {2'b00, pos_tol}) && (ady <= {2'b00, pos_tol});
    // Rotate left-half vectors into the right half plane
    if (dx[POS_W]) begin
      if (!dy[POS_W]) begin
        dat_nxt.x = dy_e;
        dat_nxt.y = -dx_e;
        dat_nxt.z = HALF_PI_Q12;
      end else begin
        dat_nxt.x = -dy_e;
        dat_nxt.y = dx_e;
        dat_nxt.z = -HALF_PI_Q12;
      end
    end else begin
      dat_nxt.x = dx_e;
      dat_nxt.y = dy_e;
      dat_nxt.z = '0;
    end
  end

  // Hold valid until downstream takes the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

FILE: sv/gtg_cordic_stage.sv
// One registered CORDIC vectoring iteration.
module gtg_cordic_stage
  import gtg_pkg::*;
#(
  parameter int SHIFT = 0
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  output logic rdy_o,
  input  vec_t dat_i,
  output logic vld_o,
  input  logic rdy_i,
  output vec_t dat_o
);

  logic vld_r;
  vec_t dat_r;
  vec_t dat_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  assign rdy_o = !vld_r || rdy_i;

  // Rotate toward the x axis and accumulate the angle
  always_comb begin
    xs = dat_i.x >>> SHIFT;
    ys = dat_i.y >>> SHIFT;
    dat_nxt = dat_i;
    if (!dat_i.y[XY_W-1] && (dat_i.y != '0)) begin
      dat_nxt.x = dat_i.x + ys;
      dat_nxt.y = dat_i.y - xs;
      dat_nxt.z = dat_i.z + ATAN_Q12[SHIFT];
    end else begin
      dat_nxt.x = dat_i.x - ys;
      dat_nxt.y = dat_i.y + xs;
      dat_nxt.z = dat_i.z - ATAN_Q12[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

FILE: sv/gtg_back.sv
// Back end: heading error test, gain multiply, saturation and output register.
module gtg_back
  import gtg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  output logic                 rdy_o,
  input  vec_t                 dat_i,
  input  logic [TOL_W-1:0]     angle_tol,
  input  logic [SPEED_W-1:0]   fwd_speed,
  input  logic [GAIN_W-1:0]    turn_gain,
  output logic                 vld_o,
  input  logic                 rdy_i,
  output logic [SPEED_W-1:0]   linear_speed,
  output logic signed [RATE_W-1:0] angular_rate,
  output mode_t                motion_mode
);

  localparam int SH_W = PROD_W - 4;

  // Multiply stage
  logic                     m_vld_r;
  logic                     m_rdy;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic                     turn_r;
  logic                     turn_nxt;
  logic                     arrived_r;
  logic signed [Z_W:0]      err;
  logic [Z_W:0]             abs_err;

  // Output stage
  logic                     o_vld_r;
  logic                     o_rdy;
  logic [SPEED_W-1:0]       speed_r;
  logic [SPEED_W-1:0]       speed_nxt;
  logic signed [RATE_W-1:0] rate_r;
  logic signed [RATE_W-1:0] rate_nxt;
  mode_t                    mode_r;
  mode_t                    mode_nxt;
  logic signed [SH_W-1:0]   sh;

  assign o_rdy = !o_vld_r || rdy_i;
  assign m_rdy = !m_vld_r || o_rdy;
  assign rdy_o = m_rdy;

  // Unwrapped heading error and bearing times gain
  always_comb begin
    err      = $signed({dat_i.z[Z_W-1], dat_i.z})
             - $signed({{(Z_W+1-HEADING_W){dat_i.heading[HEADING_W-1]}}, dat_i.heading});
    abs_err  = err[Z_W] ? (Z_W+1)'(-err) : (Z_W+1)'(err);
    turn_nxt = abs_err > {{(Z_W+1-TOL_W){1'b0}}, angle_tol};
    prod_nxt = $signed({{(PROD_W-Z_W){dat_i.z[Z_W-1]}}, dat_i.z})
             * $signed({{(PROD_W-GAIN_W){1'b0}}, turn_gain});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (m_rdy) begin
      m_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy && vld_i) begin
      prod_r    <= prod_nxt;
      turn_r    <= turn_nxt;
      arrived_r <= dat_i.arrived;
    end
  end

  // Floor divide by 16, saturate, pick the command set
  always_comb begin
    sh = prod_r[PROD_W-1:4];
    if (sh[SH_W-1:RATE_W-1] == '0 || sh[SH_W-1:RATE_W-1] == '1) begin
      rate_nxt = sh[RATE_W-1:0];
    end else if (sh[SH_W-1]) begin
      rate_nxt = {1'b1, {(RATE_W-1){1'b0}}};
    end else begin
      rate_nxt = {1'b0, {(RATE_W-1){1'b1}}};
    end
    speed_nxt = '0;
    if (arrived_r) begin
      mode_nxt = MODE_ARRIVE;
      rate_nxt = '0;
    end else if (turn_r) begin
      mode_nxt = MODE_TURN;
    end else begin
      mode_nxt  = MODE_DRIVE;
      rate_nxt  = '0;
      speed_nxt = fwd_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_rdy) begin
      o_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && m_vld_r) begin
      speed_r <= speed_nxt;
      rate_r  <= rate_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign vld_o        = o_vld_r;
  assign linear_speed = speed_r;
  assign angular_rate = rate_r;
  assign motion_mode  = mode_r;

endmodule

FILE: sim/tb_go_to_goal_heading_controller.sv
// Self-checking testbench for the go-to-goal heading controller: random poses against a predictor.
module tb_go_to_goal_heading_controller;
  import gtg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_ITERS = 14;
  localparam int LATENCY      = CORDIC_ITERS + 3;
  localparam int STUCK_LIMIT  = 2000;   // well above the long receiver hold
  localparam int RX_HOLD      = 300;

  // Register indexes that decode to nothing
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

  // atan(2^-i) in Q3.12
  localparam longint ARCTAN_STEP [21] = '{
    3217, 1899, 1003, 509, 256, 128, 64, 32, 16, 8, 4, 2, 1,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic [14:0]        speed;
    logic signed [15:0] rate;
    mode_t              mode;
  } cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [47:0]           in_tdata = '0;   // pose_x[15:0], pose_y[31:16], pose_heading[46:32]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [39:0]           out_tdata;       // linear_speed[14:0], angular_rate[30:15],
                                          // motion_mode[32:31]

  // Register shadow
  logic signed [15:0] tgt_x = 16'sd1280;
  logic signed [15:0] tgt_y = 16'sd1280;
  logic [14:0]        band_tol = 15'd128;
  logic [14:0]        aim_tol = 15'd410;
  logic [14:0]        cruise_speed = 15'd512;
  logic [7:0]         turn_gain_q4 = 8'd32;

  logic [47:0] pose_queue [$];
  cmd_t        cmd_expected [$];
  int          poses_sent = 0;
  int          cmds_seen = 0;
  int          fails = 0;
  int          rx_hold_left = 0;
  int          stuck_cycles = 0;

  go_to_goal_heading_controller #(.CORDIC_ITERATIONS(CORDIC_ITERS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CORDIC vectoring in Q3.12, quadrant fold for the left half plane
  function automatic longint cordic_bearing(input longint dx, input longint dy);
    longint x, y, z, t, xs, ys;
    x = dx;
    y = dy;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 6434;
      end else begin
        x = -y;
        y = t;
        z = -6434;
      end
    end
    for (int i = 0; i < CORDIC_ITERS && i < 21; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_STEP[i];
      end
    end
    return z;
  endfunction

  function automatic cmd_t predict_cmd(input logic signed [15:0] px, input logic signed [15:0] py,
                                       input logic signed [14:0] hd);
    cmd_t   c;
    longint dx, dy, tol, brg, err, rate;
    dx  = longint'(tgt_x) - longint'(px);
    dy  = longint'(tgt_y) - longint'(py);
    tol = longint'(band_tol);
    c.speed = '0;
    c.rate  = '0;
    if ((dx < 0 ? -dx : dx) <= tol && (dy < 0 ? -dy : dy) <= tol) begin
      c.mode = MODE_ARRIVE;
      return c;
    end
    brg = cordic_bearing(dx, dy);
    err = brg - longint'(hd);
    if ((err < 0 ? -err : err) > longint'(aim_tol)) begin
      rate = (brg * longint'(turn_gain_q4)) >>> 4;
      if (rate > 32767) rate = 32767;
      if (rate < -32768) rate = -32768;
      c.rate = rate[15:0];
      c.mode = MODE_TURN;
    end else begin
      c.speed = cruise_speed;
      c.mode  = MODE_DRIVE;
    end
    return c;
  endfunction

  function automatic logic [47:0] pose_word(input logic [15:0] x, input logic [15:0] y,
                                            input logic [14:0] h);
    return {1'b0, h, y, x};
  endfunction

  // Write one register and keep the shadow in step
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TARGET_X:  tgt_x = val;
      REG_TARGET_Y:  tgt_y = val;
      REG_POS_TOL:   band_tol = val[14:0];
      REG_ANGLE_TOL: aim_tol = val[14:0];
      REG_FWD_SPEED: cruise_speed = val[14:0];
      REG_TURN_GAIN: turn_gain_q4 = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hold until every pose is taken and every command is back
  task automatic wait_quiet();
    while (pose_queue.size() != 0 || in_tvalid || cmd_expected.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Heading offset from the bearing by up to one tolerance and a bit
  task automatic queue_near_threshold(input logic signed [15:0] px, input logic signed [15:0] py);
    longint brg;
    brg = cordic_bearing(longint'(tgt_x) - px, longint'(tgt_y) - py);
    pose_queue.push_back(pose_word(px, py, 15'(brg - aim_tol)));
    pose_queue.push_back(pose_word(px, py, 15'(brg - aim_tol - 1)));
    pose_queue.push_back(pose_word(px, py, 15'(brg + aim_tol)));
    pose_queue.push_back(pose_word(px, py, 15'(brg + aim_tol + 1)));
  endtask

  task automatic queue_random(input int n);
    logic signed [15:0] px, py;
    logic signed [14:0] hd;
    longint brg, hv, w;
    int sel, span;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      px  = 16'($urandom);
      py  = 16'($urandom);
      hd  = 15'(int'($urandom_range(0, 25736)) - 12868);
      if (sel < 20) begin
        // land around the arrival band
        span = 2 * int'(band_tol) + 2;
        px = 16'(int'(tgt_x) + int'($urandom_range(0, 2 * span)) - span);
        py = 16'(int'(tgt_y) + int'($urandom_range(0, 2 * span)) - span);
      end
      if (sel >= 20 && sel < 45) begin
        // aim close to the bearing so both sides of the threshold show up
        brg = cordic_bearing(longint'(tgt_x) - px, longint'(tgt_y) - py);
        w   = longint'(aim_tol) + 2;
        if (w > 20000) w = 20000;
        hv  = brg + longint'($urandom_range(0, 2 * w)) - w;
        if (hv > 16383) hv = 16383;
        if (hv < -16384) hv = -16384;
        hd = hv[14:0];
      end else if (sel >= 45 && sel < 50) begin
        hd = 15'($urandom);
      end
      pose_queue.push_back(pose_word(px, py, hd));
    end
  endtask

  // Sender: offer queued poses, predict on each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        cmd_expected.push_back(predict_cmd(in_tdata[15:0], in_tdata[31:16], in_tdata[46:32]));
        poses_sent++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered item
      end else if (pose_queue.size() != 0 &&
                   ((poses_sent >= 250 && poses_sent < 330) || $urandom_range(0, 99) >= 25)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pose_queue.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random ready with two long hold-offs, check each command
  always @(posedge clk) begin
    cmd_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (cmd_expected.size() == 0) begin
          $error("command item with nothing expected: %h", out_tdata);
          fails++;
        end else begin
          want = cmd_expected.pop_front();
          if (out_tdata[14:0] !== want.speed) begin
            $error("linear_speed: expected %0d, got %0d", want.speed, out_tdata[14:0]);
            fails++;
          end
          if ($signed(out_tdata[30:15]) !== want.rate) begin
            $error("angular_rate: expected %0d, got %0d", want.rate, $signed(out_tdata[30:15]));
            fails++;
          end
          if (out_tdata[32:31] !== want.mode) begin
            $error("motion_mode: expected %0d, got %0d", want.mode, out_tdata[32:31]);
            fails++;
          end
          if (out_tdata[39:33] !== 7'd0) begin
            $error("pad bits: expected 0, got %h", out_tdata[39:33]);
            fails++;
          end
        end
        cmds_seen++;
        if (cmds_seen == 150 || cmds_seen == 420) rx_hold_left = RX_HOLD;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (cmds_seen >= 250 && cmds_seen < 330) || $urandom_range(0, 99) >= 25;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[go_to_goal_heading_controller] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: arrival band edges, every quadrant, field extremes, threshold
    pose_queue.push_back(pose_word(16'sd1280, 16'sd1280, 15'sd0));
    pose_queue.push_back(pose_word(16'sd1408, 16'sd1152, 15'sd0));
    pose_queue.push_back(pose_word(16'sd1151, 16'sd1280, 15'sd0));
    pose_queue.push_back(pose_word(16'sd1280, 16'sd1480, 15'sd100));
    pose_queue.push_back(pose_word(16'sd1280, 16'sd1080, -15'sd100));
    pose_queue.push_back(pose_word(16'sd1780, 16'sd1580, 15'sd0));
    pose_queue.push_back(pose_word(16'sd1780, 16'sd980, 15'sd0));
    pose_queue.push_back(pose_word(16'sd1780, 16'sd1280, 15'sd0));
    pose_queue.push_back(pose_word(-16'sd32768, -16'sd32768, 15'sd12868));
    pose_queue.push_back(pose_word(16'sd32767, 16'sd32767, -15'sd12868));
    pose_queue.push_back(pose_word(-16'sd32768, 16'sd32767, 15'sd16383));
    pose_queue.push_back(pose_word(16'sd32767, -16'sd32768, -15'sd16384));
    pose_queue.push_back(pose_word(16'sd0, 16'sd0, 15'sd0));
    queue_near_threshold(16'sd0, 16'sd0);
    queue_random(50);
    wait_quiet();
    queue_random(50);
    wait_quiet();

    // Extremes: far corner target, zero tolerances, full speed and gain, masked bits
    write_reg(REG_TARGET_X, 16'h8000);
    write_reg(REG_TARGET_Y, 16'h8000);
    write_reg(REG_POS_TOL, 16'h8000);
    write_reg(REG_ANGLE_TOL, 16'h8000);
    write_reg(REG_FWD_SPEED, 16'hFFFF);
    write_reg(REG_TURN_GAIN, 16'hFFFF);
    write_reg(REG_SPARE_6, 16'hFFFF);
    write_reg(REG_SPARE_7, 16'h5A5A);
    @(negedge clk);
    pose_queue.push_back(pose_word(16'sd32767, -16'sd32768, 15'sd0));
    pose_queue.push_back(pose_word(16'sd32767, 16'sd32767, 15'sd0));
    pose_queue.push_back(pose_word(16'sd32767, -16'sd32767, 15'sd0));
    pose_queue.push_back(pose_word(-16'sd32768, -16'sd32768, 15'sd0));
    queue_random(80);
    wait_quiet();

    // Opposite extremes: huge bands, no speed, no gain
    write_reg(REG_TARGET_X, 16'h7FFF);
    write_reg(REG_TARGET_Y, 16'h7FFF);
    write_reg(REG_POS_TOL, 16'h7FFF);
    write_reg(REG_ANGLE_TOL, 16'h7FFF);
    write_reg(REG_FWD_SPEED, 16'h0000);
    write_reg(REG_TURN_GAIN, 16'h0000);
    @(negedge clk);
    pose_queue.push_back(pose_word(-16'sd32768, -16'sd32768, 15'sd0));
    queue_random(60);
    wait_quiet();

    // Random settings, upper data bits left random
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_TARGET_X, 16'($urandom));
      write_reg(REG_TARGET_Y, 16'($urandom));
      write_reg(REG_POS_TOL, {1'($urandom), 15'($urandom_range(0, 1024))});
      write_reg(REG_ANGLE_TOL, {1'($urandom), 15'($urandom_range(0, 2000))});
      write_reg(REG_FWD_SPEED, 16'($urandom));
      write_reg(REG_TURN_GAIN, 16'($urandom));
      @(negedge clk);
      queue_random(80);
      wait_quiet();
    end

    if (fails == 0 && cmd_expected.size() == 0) begin
      $display("[go_to_goal_heading_controller] OK");
    end else begin
      $display("[go_to_goal_heading_controller] ERROR");
    end
    $finish;
  end

endmodule
